// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when a holds, c must hold.
`define ASSERT_SAME(lbl, clk_s, rst_s, a, c, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |-> (c)) \
    else $error(msg);

// Next-cycle implication: when a holds, c must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk_s, rst_s, a, c, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (a) |=> (c)) \
    else $error(msg);

`endif

// ----- sv/i2cbs_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cbs_pkg
// Op codes, sequencer state codes and shared types for the I2C bit sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cbs_pkg;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Phase bounds of the bit loops and of the ACK handling, and the last sub-tick
  localparam logic [4:0] WR_ACK_PH  = 5'd24;
  localparam logic [4:0] RD_ACK_PH  = 5'd16;
  localparam logic [4:0] RD_WAIT_PH = 5'd19;
  localparam logic [1:0] SUB_LAST   = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_STOP  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_READ  = 5'b10000
  } st_t;

  typedef struct packed {
    st_t        st;
    logic [4:0] phase;
    logic [1:0] sub;
    logic [7:0] shift;
    logic       ack_choice;
    logic       scl_drv;
    logic       sda_drv;
    logic [7:0] rx_hold;
    logic       nack_hold;
  } seq_state_t;

  typedef struct packed {
    logic done;
    logic err;
  } step_flags_t;

endpackage

`default_nettype wire

// ----- sv/i2cbs_if.sv -----
// ----------------------------------------------------------------------------
// i2cbs_cmd_if / i2cbs_res_if
// Valid/ready channels for command and tick items, and for result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface i2cbs_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, op, tx_byte, send_ack, sda_in, input ready);
  modport sink (input valid, op, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cbs_res_if;
  logic       valid;
  logic       ready;
  logic       scl_low;
  logic       sda_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       nack_seen;
  logic       cmd_error;

  modport source (output valid, scl_low, sda_low, busy_res, done_res, rx_byte,
                  nack_seen, cmd_error, input ready);
  modport sink (input valid, scl_low, sda_low, busy_res, done_res, rx_byte,
                nack_seen, cmd_error, output ready);
endinterface

`default_nettype wire

// ----- sv/i2cbs_step.sv -----
// ----------------------------------------------------------------------------
// i2cbs_step
// Next-state logic of the sequencer for one command or tick item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_step (
  input  i2cbs_pkg::seq_state_t  cur,
  input  logic [2:0]             op,
  input  logic [7:0]             tx_byte,
  input  logic                   send_ack,
  input  logic                   sda_in,
  output i2cbs_pkg::seq_state_t  nxt,
  output i2cbs_pkg::step_flags_t flags
);

  // One tick of a sent bit: returns {scl_drv, sda_drv}
  function automatic logic [1:0] send_bit(input logic [1:0] sub, input logic b,
                                          input logic scl, input logic sda);
    logic [1:0] r;
    r = {scl, sda};
    case (sub)
      2'd0:    r = {1'b0, ~b};
      2'd1:    r = {1'b1, sda};
      default: r = {scl, (b ? 1'b1 : sda)};
    endcase
    return r;
  endfunction

  logic fin;

  always_comb begin
    nxt   = cur;
    fin   = 1'b0;
    flags = '0;
    if (op == i2cbs_pkg::OP_TICK) begin
      if (cur.st != i2cbs_pkg::ST_IDLE) begin
        case (cur.st)
          i2cbs_pkg::ST_START: begin
            if (cur.phase == 5'd0) begin
              nxt.scl_drv = 1'b0;
              nxt.sda_drv = 1'b0;
            end else if (cur.phase == 5'd1) begin
              nxt.sda_drv = 1'b1;
            end else begin
              nxt.scl_drv = 1'b1;
              fin = 1'b1;
            end
          end
          i2cbs_pkg::ST_STOP: begin
            if (cur.phase == 5'd0) begin
              nxt.scl_drv = 1'b0;
            end else begin
              nxt.sda_drv = 1'b0;
              fin = 1'b1;
            end
          end
          i2cbs_pkg::ST_WRITE: begin
            if (cur.phase < i2cbs_pkg::WR_ACK_PH) begin
              {nxt.scl_drv, nxt.sda_drv} = send_bit(cur.sub, cur.shift[7],
                                                    cur.scl_drv, cur.sda_drv);
              if (cur.sub == i2cbs_pkg::SUB_LAST) begin
                nxt.shift = {cur.shift[6:0], 1'b0};
                nxt.sub   = 2'd0;
              end else begin
                nxt.sub = cur.sub + 2'd1;
              end
            end else if (cur.phase == i2cbs_pkg::WR_ACK_PH) begin
              nxt.sda_drv = 1'b0;
              nxt.scl_drv = 1'b0;
            end else begin
              nxt.nack_hold = sda_in;
              nxt.scl_drv   = 1'b1;
              fin = 1'b1;
            end
          end
          i2cbs_pkg::ST_READ: begin
            if (cur.phase < i2cbs_pkg::RD_ACK_PH) begin
              if (!cur.phase[0]) begin
                nxt.sda_drv = 1'b0;
                nxt.scl_drv = 1'b0;
              end else begin
                nxt.shift   = {cur.shift[6:0], sda_in};
                nxt.scl_drv = 1'b1;
              end
            end else if (cur.phase < i2cbs_pkg::RD_WAIT_PH) begin
              // ACK phases 16..18 map onto sub-ticks 0..2
              {nxt.scl_drv, nxt.sda_drv} = send_bit(cur.phase[1:0], ~cur.ack_choice,
                                                    cur.scl_drv, cur.sda_drv);
            end else begin
              nxt.rx_hold = cur.shift;
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          nxt.st    = i2cbs_pkg::ST_IDLE;
          nxt.phase = 5'd0;
        end else begin
          nxt.phase = cur.phase + 5'd1;
        end
        flags.done = fin;
      end
    end else if (op > i2cbs_pkg::OP_READ || cur.st != i2cbs_pkg::ST_IDLE) begin
      // Refused command: hold all state
      flags.err = 1'b1;
    end else begin
      nxt.phase = 5'd0;
      nxt.sub   = 2'd0;
      case (op)
        i2cbs_pkg::OP_START: nxt.st = i2cbs_pkg::ST_START;
        i2cbs_pkg::OP_STOP:  nxt.st = i2cbs_pkg::ST_STOP;
        i2cbs_pkg::OP_WRITE: begin
          nxt.st    = i2cbs_pkg::ST_WRITE;
          nxt.shift = tx_byte;
        end
        i2cbs_pkg::OP_READ: begin
          nxt.st         = i2cbs_pkg::ST_READ;
          nxt.shift      = 8'd0;
          nxt.ack_choice = send_ack;
        end
        default: nxt.st = cur.st;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/i2c_master_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Open-drain I2C master that steps SCL/SDA drive on tick items.
// ----------------------------------------------------------------------------
// Each input item is a command (start, stop, write byte, read byte) or a tick
// that stands for one bus delay period and carries the SDA level sampled
// during that period. Every item yields exactly one result item that shows
// the pin drive for the coming delay (1 = pull low), busy, a done pulse on
// the completing tick, the last read byte, the last write ACK bit and an
// error flag for a refused command. The block takes one item per clock: the
// next-state logic sits between the sequencer registers and a single result
// register, so an item is taken whenever the result register is empty or its
// item is being taken in the same cycle, and each result appears in the cycle
// after its item. A start spans 3 ticks, a stop 2, a write 26 and a read 20.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module i2c_master_bit_sequencer (
  input  logic        clk,
  input  logic        rst,
  i2cbs_cmd_if.sink   cmd,
  i2cbs_res_if.source res
);

  i2cbs_pkg::seq_state_t  st;
  i2cbs_pkg::seq_state_t  st_next;
  i2cbs_pkg::step_flags_t flags;
  logic                   res_valid;
  logic                   cmd_acc;

  // Take an item when the result slot is free or drains this cycle
  assign cmd.ready = !res_valid || res.ready;
  assign cmd_acc   = cmd.valid && cmd.ready;

  i2cbs_step u_step (
    .cur      (st),
    .op       (cmd.op),
    .tx_byte  (cmd.tx_byte),
    .send_ack (cmd.send_ack),
    .sda_in   (cmd.sda_in),
    .nxt      (st_next),
    .flags    (flags)
  );

  // Sequencer state: advance only on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{st: i2cbs_pkg::ST_IDLE, phase: 5'd0, sub: 2'd0, shift: 8'd0,
              ack_choice: 1'b0, scl_drv: 1'b0, sda_drv: 1'b0, rx_hold: 8'd0,
              nack_hold: 1'b0};
    end else if (cmd_acc) begin
      st <= st_next;
    end
  end

  // Result register: load the post-item view, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_acc) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc) begin
      res.scl_low   <= st_next.scl_drv;
      res.sda_low   <= st_next.sda_drv;
      res.busy_res  <= (st_next.st != i2cbs_pkg::ST_IDLE);
      res.done_res  <= flags.done;
      res.rx_byte   <= st_next.rx_hold;
      res.nack_seen <= st_next.nack_hold;
      res.cmd_error <= flags.err;
    end
  end

  assign res.valid = res_valid;

  // Checks
  `ASSERT_SAME(a_no_acc_on_stall, clk, rst, res_valid && !res.ready, !cmd_acc,
               "item taken while result stalled")
  `ASSERT_NEXT(a_err_keeps_state, clk, rst, cmd_acc && flags.err, st == $past(st),
               "refused command changed state")
  `ASSERT_SAME(a_idle_phase_zero, clk, rst, st.st == i2cbs_pkg::ST_IDLE,
               st.phase == 5'd0, "idle with nonzero phase")
  `ASSERT_SAME(a_done_not_busy, clk, rst, res_valid && res.done_res,
               !res.busy_res && !res.cmd_error, "done with busy or error")

endmodule

`default_nettype wire
